[rtl/cbd_pkg.sv]
// Shared types, item codes and field widths for the CPU bus decoder with
// sprite-memory DMA. Used by cbd_decode and cpu_bus_decode_oam_dma_core.
`default_nettype none

package cbd_pkg;

   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int PHASE_W = 3;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   localparam logic [2:0] TGT_NONE  = 3'd0;
   localparam logic [2:0] TGT_CART  = 3'd1;
   localparam logic [2:0] TGT_RAM   = 3'd2;
   localparam logic [2:0] TGT_PPU   = 3'd3;
   localparam logic [2:0] TGT_PAD1  = 3'd4;
   localparam logic [2:0] TGT_PAD2  = 3'd5;
   localparam logic [2:0] TGT_PADS  = 3'd6;
   localparam logic [2:0] TGT_DMA   = 3'd7;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_PEEK  = 2'd2;

   localparam logic [ADDR_W-1:0] RAM_MASK    = 16'h07FF;
   localparam logic [ADDR_W-1:0] RAM_TOP     = 16'h1FFF;
   localparam logic [ADDR_W-1:0] PPU_TOP     = 16'h3FFF;
   localparam logic [ADDR_W-1:0] PPU_MASK    = 16'h0007;
   localparam logic [ADDR_W-1:0] PAD1_ADDR   = 16'h4016;
   localparam logic [ADDR_W-1:0] PAD2_ADDR   = 16'h4017;
   localparam logic [ADDR_W-1:0] OAM_DMA_REG = 16'h4014;

   localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;
   localparam logic [PHASE_W-1:0] PHASE_A    = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_B    = 3'd3;

   localparam logic CSR_IDX_CTRL = 1'b0;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] write_data;
      logic              peek_only;
      logic              cart_claims;
      logic [BYTE_W-1:0] fetched_data;
      logic              ppu_nmi;
   } item_type;

   typedef struct packed {
      logic [2:0]        target;
      logic [ADDR_W-1:0] bus_address;
      logic [1:0]        access_kind;
      logic [BYTE_W-1:0] bus_data;
      logic              oam_write;
      logic [BYTE_W-1:0] oam_index;
      logic [BYTE_W-1:0] oam_data;
      logic              cpu_step;
      logic              dma_busy;
      logic              cpu_nmi;
   } result_type;

   typedef struct packed {
      logic [PHASE_W-1:0] tick_phase;
      logic               dma_running;
      logic               dma_align_wait;
      logic [BYTE_W-1:0]  dma_source_page;
      logic [BYTE_W-1:0]  dma_byte_index;
   } state_type;

endpackage

`default_nettype wire

[rtl/cpu_bus_decode_oam_dma_core.sv]
// CPU bus decoder and sprite-memory DMA engine, top level.
// Depends on cbd_pkg and cbd_decode.
//
// Use:
//   req channel: one item per handshake; tuser carries the item mode (tick,
//   CPU read, CPU write), tdata the address, write byte, flags, DMA fetch byte
//   and PPU NMI request.
//   rsp channel: exactly one result item per request item, in order. tuser
//   carries the bus target and access kind, tdata the local address, data,
//   sprite-memory write, CPU step, DMA busy and CPU NMI.
//   csr port: register 0 (controllers_present, 2 bits) at byte address 0.
//   Write it only while no items are in flight.
// Timing:
//   An accepted item is held in an input register, decoded combinationally
//   and lands in the result register, which drives rsp_tvalid. Throughput is
//   one item per cycle while the receiver does not stall; the state update
//   (tick phase, DMA page and index) loops back through the decoder.
// Reset clears phase and DMA state, arms align_wait, empties both registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then req_tready drops until rsp_tready returns.
`default_nettype none

module cpu_bus_decode_oam_dma_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [15:0] address, [23:16] write_data, [24] peek_only, [25] cart_claims,
   // [33:26] fetched_data, [34] ppu_nmi, [39:35] zero
   input  wire  [39:0] req_tdata,
   // [1:0] mode
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [15:0] bus_address, [23:16] bus_data, [24] oam_write, [32:25] oam_index,
   // [40:33] oam_data, [41] cpu_step, [42] dma_busy, [43] cpu_nmi, [47:44] zero
   output logic [47:0] rsp_tdata,
   // [2:0] target, [4:3] access_kind
   output logic [4:0]  rsp_tuser,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   cbd_pkg::item_type    in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   cbd_pkg::result_type  out_res_ff;
   cbd_pkg::state_type   state_ff, state_in;
   logic [1:0]           pads_ff, pads_in;

   cbd_pkg::item_type    req_item;
   cbd_pkg::result_type  dec_res;
   logic                 out_ready;
   logic                 advance;
   logic                 req_fire;
   logic                 csr_write;

   assign req_item.mode         = req_tuser;
   assign req_item.address      = req_tdata[15:0];
   assign req_item.write_data   = req_tdata[23:16];
   assign req_item.peek_only    = req_tdata[24];
   assign req_item.cart_claims  = req_tdata[25];
   assign req_item.fetched_data = req_tdata[33:26];
   assign req_item.ppu_nmi      = req_tdata[34];

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign req_fire   = req_tvalid && req_tready;

   cbd_decode u_decode (
      .item         (in_item_ff),
      .state        (state_ff),
      .pads_present (pads_ff),
      .result       (dec_res),
      .state_next   (state_in)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pads_in = pads_ff;
      if (csr_write && csr_paddr[2] == cbd_pkg::CSR_IDX_CTRL) begin
         pads_in = csr_pwdata[1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == cbd_pkg::CSR_IDX_CTRL) begin
         csr_prdata = {30'd0, pads_ff};
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pads_ff      <= '0;
         state_ff     <= '{tick_phase: '0, dma_running: 1'b0, dma_align_wait: 1'b1,
                           dma_source_page: '0, dma_byte_index: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pads_ff      <= pads_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_res_ff.access_kind, out_res_ff.target};
   assign rsp_tdata  = {4'd0, out_res_ff.cpu_nmi, out_res_ff.dma_busy, out_res_ff.cpu_step,
                        out_res_ff.oam_data, out_res_ff.oam_index, out_res_ff.oam_write,
                        out_res_ff.bus_data, out_res_ff.bus_address};

   // idle DMA leaves index at zero and the alignment flag armed
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !state_ff.dma_running |-> state_ff.dma_byte_index == '0)
      else $error("DMA index nonzero while idle");

   a_idle_align: assert property (@(posedge clock) disable iff (reset)
      !state_ff.dma_running |-> state_ff.dma_align_wait)
      else $error("alignment flag clear while idle");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.tick_phase <= cbd_pkg::PHASE_LAST)
      else $error("tick phase out of range");

   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.cpu_step |->
         !out_res_ff.dma_busy && !out_res_ff.oam_write &&
         out_res_ff.target == cbd_pkg::TGT_NONE)
      else $error("CPU step during DMA activity");

endmodule

`default_nettype wire

[rtl/cbd_decode.sv]
// Single-pass decode of one item: address routing, DMA sequencing, tick phase.
// Depends on cbd_pkg for the item, result and state types.
`default_nettype none

module cbd_decode (
   input  wire cbd_pkg::item_type   item,
   input  wire cbd_pkg::state_type  state,
   input  wire [1:0]                pads_present,
   output cbd_pkg::result_type      result,
   output cbd_pkg::state_type       state_next
);

   logic [cbd_pkg::PHASE_W-1:0] phase;
   logic                        slot;
   logic                        odd;
   logic                        is_write;
   logic [cbd_pkg::BYTE_W-1:0]  data;
   logic [cbd_pkg::BYTE_W-1:0]  index_inc;

   always_comb begin
      result     = '0;
      state_next = state;
      phase      = (state.tick_phase > cbd_pkg::PHASE_LAST) ? cbd_pkg::PHASE_A
                                                            : state.tick_phase;
      slot       = (phase == cbd_pkg::PHASE_A) || (phase == cbd_pkg::PHASE_B);
      odd        = phase[0];
      is_write   = (item.mode == cbd_pkg::MODE_WRITE);
      data       = item.write_data;
      index_inc  = state.dma_byte_index + 8'd1;
      case (item.mode)
         cbd_pkg::MODE_TICK: begin
            if (slot) begin
               if (state.dma_running) begin
                  if (state.dma_align_wait && odd) begin
                     state_next.dma_align_wait = 1'b0;
                  end else if (!odd) begin
                     result.target      = cbd_pkg::TGT_DMA;
                     result.bus_address = {state.dma_source_page, state.dma_byte_index};
                  end else begin
                     result.oam_write = 1'b1;
                     result.oam_index = state.dma_byte_index;
                     result.oam_data  = item.fetched_data;
                     state_next.dma_byte_index = index_inc;
                     if (index_inc == '0) begin
                        state_next.dma_running    = 1'b0;
                        state_next.dma_align_wait = 1'b1;
                     end
                  end
               end else begin
                  result.cpu_step = 1'b1;
               end
            end
            result.cpu_nmi        = item.ppu_nmi;
            state_next.tick_phase = (phase == cbd_pkg::PHASE_LAST) ? cbd_pkg::PHASE_A
                                                                   : phase + 3'd1;
         end
         cbd_pkg::MODE_READ, cbd_pkg::MODE_WRITE: begin
            if (item.cart_claims) begin
               result.target      = cbd_pkg::TGT_CART;
               result.bus_address = item.address;
            end else if (item.address <= cbd_pkg::RAM_TOP) begin
               result.target      = cbd_pkg::TGT_RAM;
               result.bus_address = item.address & cbd_pkg::RAM_MASK;
            end else if (item.address <= cbd_pkg::PPU_TOP) begin
               result.target      = cbd_pkg::TGT_PPU;
               result.bus_address = item.address & cbd_pkg::PPU_MASK;
            end else if (item.address == cbd_pkg::PAD1_ADDR) begin
               if (is_write) begin
                  case (pads_present)
                     2'b11:   result.target = cbd_pkg::TGT_PADS;
                     2'b01:   result.target = cbd_pkg::TGT_PAD1;
                     2'b10:   result.target = cbd_pkg::TGT_PAD2;
                     default: result.target = cbd_pkg::TGT_NONE;
                  endcase
                  data = {7'd0, item.write_data[0]};
               end else if (pads_present[0]) begin
                  result.target = cbd_pkg::TGT_PAD1;
               end
               if (result.target != cbd_pkg::TGT_NONE) begin
                  result.bus_address = item.address;
               end
            end else if (item.address == cbd_pkg::PAD2_ADDR) begin
               if (!is_write && pads_present[1]) begin
                  result.target      = cbd_pkg::TGT_PAD2;
                  result.bus_address = item.address;
               end
            end else if (item.address == cbd_pkg::OAM_DMA_REG && is_write) begin
               state_next.dma_running     = 1'b1;
               state_next.dma_byte_index  = '0;
               state_next.dma_source_page = item.write_data;
            end
            if (result.target != cbd_pkg::TGT_NONE) begin
               if (is_write) begin
                  result.access_kind = cbd_pkg::KIND_WRITE;
                  result.bus_data    = data;
               end else if (item.peek_only) begin
                  result.access_kind = cbd_pkg::KIND_PEEK;
               end else begin
                  result.access_kind = cbd_pkg::KIND_READ;
               end
            end
         end
         default: begin
         end
      endcase
      result.dma_busy = state_next.dma_running;
   end

endmodule

`default_nettype wire
